// ===== rtl/core/lev_pkg.sv =====
// ----------------------------------------------------------------------------
// lev_pkg: shared types and constants for the edit-distance row engine
// Row geometry, register map codes, the configuration bundle and the token
// that moves from cell to cell along the row.
// ----------------------------------------------------------------------------
package lev_pkg;

    // Row geometry
    localparam int MAX_PATTERN = 32;
    localparam int ROW_DEPTH   = MAX_PATTERN + 1;
    localparam int IDX_W       = 6;
    localparam int DIST_W      = 4;
    localparam int EDIT_W      = 3;
    localparam int SYM_W       = 8;

    // Ramp saturation under the reset edit limit of one
    localparam logic [DIST_W-1:0] RESET_SAT = 4'd2;
    localparam logic [EDIT_W-1:0] RESET_MAX_EDITS = 3'd1;

    // Filler value on the left of cell 0, so it never wins the minimum
    localparam logic [DIST_W-1:0] DIST_FAR = 4'hF;

    // Configuration port
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam logic [2:0] REG_PAT_0_7   = 3'd0;
    localparam logic [2:0] REG_PAT_8_15  = 3'd1;
    localparam logic [2:0] REG_PAT_16_23 = 3'd2;
    localparam logic [2:0] REG_PAT_24_31 = 3'd3;
    localparam logic [2:0] REG_PAT_LEN   = 3'd4;
    localparam logic [2:0] REG_MAX_EDITS = 3'd5;

    // Request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_CHAR  = 1'b1;

    // Configuration bundle from the register file
    typedef struct packed {
        logic [8*MAX_PATTERN-1:0] pattern;
        logic [IDX_W-1:0]         pattern_length;
        logic [EDIT_W-1:0]        max_edits;
    } lev_cfg_t;

    // Token handed from one cell to the next
    typedef struct packed {
        logic              valid;
        logic              is_char;
        logic [SYM_W-1:0]  sym;
        logic [DIST_W-1:0] old_left;
        logic [DIST_W-1:0] new_left;
        logic              any;
        logic [DIST_W-1:0] endv;
    } lev_tok_t;

endpackage

// ===== rtl/core/lev_regs.sv =====
// ----------------------------------------------------------------------------
// lev_regs: configuration register file
// APB-style slave holding the pattern bytes, pattern length and edit limit.
// Registers are 64 bits wide at byte addresses 8*i; pready is tied high.
// ----------------------------------------------------------------------------
module lev_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lev_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lev_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lev_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output lev_pkg::lev_cfg_t               cfg
);

    logic [63:0]                    pat_reg [4];
    logic [lev_pkg::IDX_W-1:0]      len_reg;
    logic [lev_pkg::EDIT_W-1:0]     edits_reg;
    logic [2:0]                     reg_idx;
    logic                           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg[0] <= '0;
            pat_reg[1] <= '0;
            pat_reg[2] <= '0;
            pat_reg[3] <= '0;
            len_reg    <= '0;
            edits_reg  <= lev_pkg::RESET_MAX_EDITS;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                lev_pkg::REG_PAT_0_7:   pat_reg[0] <= pwdata;
                lev_pkg::REG_PAT_8_15:  pat_reg[1] <= pwdata;
                lev_pkg::REG_PAT_16_23: pat_reg[2] <= pwdata;
                lev_pkg::REG_PAT_24_31: pat_reg[3] <= pwdata;
                lev_pkg::REG_PAT_LEN:   len_reg    <= pwdata[lev_pkg::IDX_W-1:0];
                lev_pkg::REG_MAX_EDITS: edits_reg  <= pwdata[lev_pkg::EDIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        unique case (reg_idx)
            lev_pkg::REG_PAT_0_7:   prdata = pat_reg[0];
            lev_pkg::REG_PAT_8_15:  prdata = pat_reg[1];
            lev_pkg::REG_PAT_16_23: prdata = pat_reg[2];
            lev_pkg::REG_PAT_24_31: prdata = pat_reg[3];
            lev_pkg::REG_PAT_LEN:   prdata = {58'd0, len_reg};
            lev_pkg::REG_MAX_EDITS: prdata = {61'd0, edits_reg};
            default:                prdata = '0;
        endcase
    end

    assign cfg.pattern        = {pat_reg[3], pat_reg[2], pat_reg[1], pat_reg[0]};
    assign cfg.pattern_length = len_reg;
    assign cfg.max_edits      = edits_reg;

endmodule

// ===== rtl/core/lev_cell.sv =====
// ----------------------------------------------------------------------------
// lev_cell: one cell of the edit-distance row
// Holds one saturated row entry. When a token arrives it computes the new
// entry from its left neighbour's old and new values, then passes its own old
// and new values, plus the running report, on to the right.
// ----------------------------------------------------------------------------
module lev_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic [lev_pkg::IDX_W-1:0]      idx,
    input  logic [lev_pkg::SYM_W-1:0]      pchar,
    input  logic [lev_pkg::EDIT_W-1:0]     max_edits,
    input  logic [lev_pkg::IDX_W-1:0]      end_idx,
    input  lev_pkg::lev_tok_t              tok_in,
    output lev_pkg::lev_tok_t              tok_out
);

    logic [lev_pkg::DIST_W-1:0] dist_reg;
    logic [lev_pkg::DIST_W-1:0] dist_next;
    lev_pkg::lev_tok_t          tok_reg;
    lev_pkg::lev_tok_t          tok_next;
    logic [lev_pkg::DIST_W-1:0] sat;
    logic [lev_pkg::DIST_W:0]   sub_c;
    logic [lev_pkg::DIST_W:0]   ins_c;
    logic [lev_pkg::DIST_W:0]   del_c;
    logic [lev_pkg::DIST_W:0]   best;
    logic                       in_range;

    assign sat = {1'b0, max_edits} + 4'd1;

    // New entry: minimum of substitute, insert and delete, then saturate
    always_comb
    begin
        sub_c = {1'b0, tok_in.old_left} + {4'd0, (pchar != tok_in.sym)};
        ins_c = {1'b0, tok_in.new_left} + 5'd1;
        del_c = {1'b0, dist_reg} + 5'd1;
        best  = sub_c;
        if (ins_c < best)
        begin
            best = ins_c;
        end
        if (del_c < best)
        begin
            best = del_c;
        end
        if (tok_in.is_char == lev_pkg::REQ_CHAR)
        begin
            dist_next = (best > {1'b0, sat}) ? sat : best[lev_pkg::DIST_W-1:0];
        end
        else
        begin
            // start of a word: ramp value for this position
            dist_next = (idx > {2'b00, sat}) ? sat : idx[lev_pkg::DIST_W-1:0];
        end
    end

    // Running report for the cells inside the pattern
    assign in_range = (idx <= end_idx) && (dist_next <= {1'b0, max_edits});

    always_comb
    begin
        tok_next          = tok_in;
        tok_next.old_left = dist_reg;
        tok_next.new_left = dist_next;
        tok_next.any      = tok_in.any | in_range;
        tok_next.endv     = (idx == end_idx) ? dist_next : tok_in.endv;
    end

    // Row entry and outgoing token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= (idx > {2'b00, lev_pkg::RESET_SAT}) ? lev_pkg::RESET_SAT
                                                            : idx[lev_pkg::DIST_W-1:0];
            tok_reg  <= '0;
        end
        else if (en)
        begin
            if (tok_in.valid)
            begin
                dist_reg <= dist_next;
            end
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/core/levenshtein_automaton_step_top.sv =====
// ----------------------------------------------------------------------------
// levenshtein_automaton_step_top: edit-distance row over a configured pattern
// Feeds candidate characters through a row of 33 cells and reports match
// status for every transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Program the pattern bytes, pattern length and edit limit over the APB
//   port while no transaction is in flight. Then send one transaction per
//   word start (req_type 0) and one per candidate character (req_type 1).
//   The input channel accepts on in_valid high and in_stall low; the output
//   channel delivers on out_valid high and out_stall low.
//   Each transaction travels the row as a wavefront, one cell per cycle
//   while the chain advances. A new transaction can be taken every cycle
//   while in_stall is low: throughput is one per cycle, set by the cell
//   chain. When the receiver stalls a waiting result, the whole chain
//   freezes and in_stall rises until the result is taken.
//   Reset empties the chain, clears the pattern and length, sets the edit
//   limit to one and loads the row with the ramp 0,1,2,2,...
// ----------------------------------------------------------------------------
module levenshtein_automaton_step_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [7:0]                      symbol,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            is_match,
    output logic                            can_match,
    output logic [3:0]                      end_distance,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lev_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lev_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lev_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    lev_pkg::lev_cfg_t              cfg;
    lev_pkg::lev_tok_t              inj_reg;
    lev_pkg::lev_tok_t              chain [lev_pkg::ROW_DEPTH+1];
    lev_pkg::lev_tok_t              last_tok;
    logic [lev_pkg::IDX_W-1:0]      end_idx;
    logic                           en;

    lev_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pattern length clamped to MAX_PATTERN
    assign end_idx = (cfg.pattern_length > lev_pkg::IDX_W'(lev_pkg::MAX_PATTERN))
                   ? lev_pkg::IDX_W'(lev_pkg::MAX_PATTERN) : cfg.pattern_length;

    // Chain advances unless the result at its end is held back
    assign last_tok = chain[lev_pkg::ROW_DEPTH];
    assign en       = !(last_tok.valid && out_stall);
    assign in_stall = !en;

    // Injection stage: filler on the left of cell 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inj_reg <= '0;
        end
        else if (en)
        begin
            inj_reg.valid    <= in_valid;
            inj_reg.is_char  <= req_type;
            inj_reg.sym      <= symbol;
            inj_reg.old_left <= lev_pkg::DIST_FAR;
            inj_reg.new_left <= lev_pkg::DIST_FAR;
            inj_reg.any      <= 1'b0;
            inj_reg.endv     <= '0;
        end
    end

    assign chain[0] = inj_reg;

    // Row of cells; cell i compares against pattern byte i-1
    for (genvar i = 0; i < lev_pkg::ROW_DEPTH; i++)
    begin : g_cell
        logic [lev_pkg::SYM_W-1:0] pchar;

        if (i == 0)
        begin : g_first
            assign pchar = '0;
        end
        else
        begin : g_rest
            assign pchar = cfg.pattern[8*(i-1) +: 8];
        end

        lev_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .idx       (lev_pkg::IDX_W'(i)),
            .pchar     (pchar),
            .max_edits (cfg.max_edits),
            .end_idx   (end_idx),
            .tok_in    (chain[i]),
            .tok_out   (chain[i+1])
        );
    end

    // Result taken from the last cell's token register
    assign out_valid    = last_tok.valid;
    assign is_match     = (last_tok.endv <= {1'b0, cfg.max_edits});
    assign can_match    = last_tok.any;
    assign end_distance = last_tok.endv;

endmodule

// ===== tb/sv/levenshtein_automaton_step_checker.sv =====
// ----------------------------------------------------------------------------
// levenshtein_automaton_step_checker: row predictor and result scoreboard
// Mirrors the register writes and every accepted transaction into its own
// copy of the edit-distance row, queues the report that each transaction
// should produce and compares delivered reports with it, field by field.
// ----------------------------------------------------------------------------
module levenshtein_automaton_step_checker
    import lev_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  req_type,
    input  logic [SYM_W-1:0]      symbol,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  is_match,
    input  logic                  can_match,
    input  logic [DIST_W-1:0]     end_distance,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic              is_match;
        logic              can_match;
        logic [DIST_W-1:0] end_distance;
    } row_report_t;

    // Mirrored configuration and row
    logic [8*MAX_PATTERN-1:0] mirror_pattern;
    logic [IDX_W-1:0]         mirror_length;
    logic [EDIT_W-1:0]        mirror_max_edits;
    logic [DIST_W-1:0]        mirror_row [0:ROW_DEPTH-1];

    row_report_t expected_reports [$];
    row_report_t oldest;

    // Advance the mirrored row by one transaction and work out its report.
    // A 3-bit edit limit can never exceed the cap of seven, so no clamp.
    function automatic row_report_t advance_row(input logic kind, input logic [SYM_W-1:0] sym);
        int          lim;
        int          sat;
        int          n;
        int          v;
        int          ins;
        int          del;
        int          nxt [0:ROW_DEPTH-1];
        row_report_t rep;
        lim = int'(mirror_max_edits);
        sat = lim + 1;
        n   = (int'(mirror_length) > MAX_PATTERN) ? MAX_PATTERN : int'(mirror_length);
        if (kind == REQ_START)
        begin
            // fresh ramp, saturated one above the current limit
            for (int i = 0; i < ROW_DEPTH; i++)
                nxt[i] = (i > sat) ? sat : i;
        end
        else
        begin
            // whole row is recomputed whatever the pattern length;
            // positions stay below the 32 stored bytes
            v = int'(mirror_row[0]) + 1;
            nxt[0] = (v > sat) ? sat : v;
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                v   = int'(mirror_row[i]) + ((mirror_pattern[8*i +: 8] != sym) ? 1 : 0);
                ins = nxt[i] + 1;
                del = int'(mirror_row[i+1]) + 1;
                if (ins < v) v = ins;
                if (del < v) v = del;
                nxt[i+1] = (v > sat) ? sat : v;
            end
        end
        for (int i = 0; i < ROW_DEPTH; i++)
            mirror_row[i] = DIST_W'(nxt[i]);

        // report on the updated row, against the current limit
        rep.can_match = 1'b0;
        for (int i = 0; i <= n; i++)
            if (int'(mirror_row[i]) <= lim)
                rep.can_match = 1'b1;
        v = int'(mirror_row[n]);
        if (v > sat) v = sat;
        rep.end_distance = DIST_W'(v);
        rep.is_match     = (v <= lim);
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_pattern   = '0;
            mirror_length    = '0;
            mirror_max_edits = RESET_MAX_EDITS;
            for (int i = 0; i < ROW_DEPTH; i++)
                mirror_row[i] = (i > int'(RESET_SAT)) ? RESET_SAT : DIST_W'(i);
            expected_reports.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_ADDR_W-1:3])
                    REG_PAT_0_7:   mirror_pattern[63:0]    = pwdata;
                    REG_PAT_8_15:  mirror_pattern[127:64]  = pwdata;
                    REG_PAT_16_23: mirror_pattern[191:128] = pwdata;
                    REG_PAT_24_31: mirror_pattern[255:192] = pwdata;
                    REG_PAT_LEN:   mirror_length           = pwdata[IDX_W-1:0];
                    REG_MAX_EDITS: mirror_max_edits        = pwdata[EDIT_W-1:0];
                    default: ;
                endcase
            end

            // accepted transaction
            if (in_valid && !in_stall)
                expected_reports.push_back(advance_row(req_type, symbol));

            // delivered report
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: report with none expected, actual %0d/%0d/%0d",
                             $time, is_match, can_match, end_distance);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_reports.pop_front();
                    if (is_match !== oldest.is_match)
                    begin
                        $display("%0t: is_match expected %0d actual %0d",
                                 $time, oldest.is_match, is_match);
                        fail_count++;
                    end
                    if (can_match !== oldest.can_match)
                    begin
                        $display("%0t: can_match expected %0d actual %0d",
                                 $time, oldest.can_match, can_match);
                        fail_count++;
                    end
                    if (end_distance !== oldest.end_distance)
                    begin
                        $display("%0t: end_distance expected %0d actual %0d",
                                 $time, oldest.end_distance, end_distance);
                        fail_count++;
                    end
                end
            end
            pending <= expected_reports.size();
        end
    end

endmodule

// ===== tb/sv/levenshtein_automaton_step_top_test.sv =====
// ----------------------------------------------------------------------------
// levenshtein_automaton_step_top_test: stimulus and verdict for the row engine
// Programs patterns, lengths and edit limits over APB, then feeds start and
// character transactions: a short directed set, then phases of near-miss
// words built from the pattern, mixed with noise and stray starts. Both
// channels idle at random; the checker beside the block scores every report.
// ----------------------------------------------------------------------------
module levenshtein_automaton_step_top_test;

    import lev_pkg::*;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  req_type     = REQ_START;
    logic [SYM_W-1:0]      symbol       = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic                  is_match;
    logic                  can_match;
    logic [DIST_W-1:0]     end_distance;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;

    // stimulus state
    logic [SYM_W-1:0] pat_store [0:MAX_PATTERN-1];
    int               alpha    = 256;
    int               tx_mode  = 1;
    int               rx_mode  = 1;
    int               rx_wait  = 0;
    int               rx_draw;
    int               items_sent = 0;
    int               phase;
    int               kind;
    int               target;
    int               len_cfg;
    int               prev_len = 0;
    int               me_cfg;
    int               n_eff;
    int               edits_left;
    int               edit_pct;
    int               stop_at;
    logic             full_cfg;
    logic [63:0]      junk;

    levenshtein_automaton_step_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .symbol       (symbol),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_match     (is_match),
        .can_match    (can_match),
        .end_distance (end_distance),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    levenshtein_automaton_step_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .symbol       (symbol),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_match     (is_match),
        .can_match    (can_match),
        .end_distance (end_distance),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle cycles per transaction: none, uniform, or mostly none with bursts
    function automatic int draw_wait(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 18);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
        endcase
    endfunction

    // Character from the current phase alphabet
    function automatic logic [SYM_W-1:0] pick_symbol();
        if (alpha >= 256)
            return SYM_W'($urandom);
        return 8'h61 + SYM_W'($urandom_range(0, alpha - 1));
    endfunction

    // Receiver: after each report taken, stall for a drawn number of cycles
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            rx_draw = draw_wait(rx_mode);
            rx_wait   <= rx_draw;
            out_stall <= (rx_draw != 0);
        end
        else if (rx_wait != 0)
        begin
            rx_wait   <= rx_wait - 1;
            out_stall <= (rx_wait > 1);
        end
    end

    // One APB write: setup, access, then idle
    task automatic apb_write(input logic [2:0] reg_code, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_code, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Pattern registers are consecutive codes from REG_PAT_0_7
    task automatic load_pattern();
        logic [63:0] word;
        for (int r = 0; r < 4; r++)
        begin
            for (int b = 0; b < 8; b++)
                word[8*b +: 8] = pat_store[8*r + b];
            apb_write(REG_PAT_0_7 + 3'(r), word);
        end
    endtask

    // One transaction, after a drawn gap; valid stays up for the next one
    task automatic send_item(input logic req, input logic [SYM_W-1:0] sym);
        int gap;
        gap = draw_wait(tx_mode);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        symbol   <= sym;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Hold off until every queued report has been delivered
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        #5000000;
        $display("levenshtein_automaton_step_top_test NOT OK");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme bytes in the pattern, exact, inserted and
        // deleted characters
        for (int k = 0; k < MAX_PATTERN; k++)
            pat_store[k] = SYM_W'($urandom);
        pat_store[0] = 8'h00;
        pat_store[1] = 8'hFF;
        pat_store[2] = 8'h61;
        pat_store[3] = 8'h62;
        load_pattern();
        apb_write(REG_PAT_LEN, 64'd4);
        apb_write(REG_MAX_EDITS, 64'd1);
        send_item(REQ_START, 8'hFF);
        send_item(REQ_CHAR, 8'h00);
        send_item(REQ_CHAR, 8'hFF);
        send_item(REQ_CHAR, 8'h61);
        send_item(REQ_CHAR, 8'h62);
        send_item(REQ_CHAR, 8'h62);
        send_item(REQ_CHAR, 8'h78);
        send_item(REQ_START, 8'h00);
        send_item(REQ_CHAR, 8'hFF);
        send_item(REQ_CHAR, 8'h61);
        send_item(REQ_CHAR, 8'h62);

        // limit and length changed in the middle of a word
        wait_idle();
        apb_write(REG_PAT_LEN, 64'd2);
        apb_write(REG_MAX_EDITS, 64'd7);
        send_item(REQ_CHAR, 8'h00);
        send_item(REQ_CHAR, 8'h7A);
        // start with a limit above the pattern length
        send_item(REQ_START, 8'h55);

        // length beyond the row, zero limit
        wait_idle();
        apb_write(REG_PAT_LEN, 64'd63);
        apb_write(REG_MAX_EDITS, 64'd0);
        send_item(REQ_START, 8'hAA);
        send_item(REQ_CHAR, 8'h00);
        send_item(REQ_CHAR, 8'hFF);

        // Random phases
        for (phase = 0; phase < 12; phase++)
        begin
            wait_idle();
            case (phase)
                0: begin len_cfg = 0;  me_cfg = 0; end
                1: begin len_cfg = 32; me_cfg = 7; end
                2: begin len_cfg = 63; me_cfg = 3; end
                3: begin len_cfg = 1;  me_cfg = 7; end
                default:
                begin
                    if ($urandom_range(0, 4) == 0)
                        len_cfg = $urandom_range(33, 63);
                    else
                        len_cfg = $urandom_range(0, 32);
                    me_cfg = $urandom_range(0, 7);
                end
            endcase
            full_cfg = (phase < 4) || ($urandom_range(0, 2) != 0);
            junk = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;

            if (full_cfg)
            begin
                alpha = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 6);
                for (int k = 0; k < MAX_PATTERN; k++)
                    pat_store[k] = pick_symbol();
                load_pattern();
                apb_write(REG_PAT_LEN, (junk & ~64'h3F) | 64'(len_cfg));
            end
            apb_write(REG_MAX_EDITS, (junk & ~64'h7) | 64'(me_cfg));
            // length register kept from the previous phase
            if (!full_cfg)
                len_cfg = prev_len;
            prev_len = len_cfg;
            n_eff = (len_cfg > MAX_PATTERN) ? MAX_PATTERN : len_cfg;

            case (phase)
                0:       begin tx_mode = 0; rx_mode <= 0; end
                1:       begin tx_mode = 1; rx_mode <= 1; end
                default: begin tx_mode = $urandom_range(0, 2); rx_mode <= $urandom_range(0, 2); end
            endcase

            // carry on with the word in flight under the new settings
            if (!full_cfg || $urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, 5)) send_item(REQ_CHAR, pick_symbol());

            target = items_sent + 120;
            while (items_sent < target)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 7)
                begin
                    // near-miss word built from the pattern; the last kind is
                    // pushed well past the limit
                    send_item(REQ_START, SYM_W'($urandom));
                    edits_left = (kind == 6) ? me_cfg + 4 : $urandom_range(0, me_cfg + 1);
                    edit_pct   = $urandom_range(5, 40);
                    stop_at    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_eff) : n_eff;
                    for (int j = 0; j < stop_at; j++)
                    begin
                        if (edits_left > 0 && $urandom_range(0, 99) < edit_pct)
                        begin
                            edits_left--;
                            case ($urandom_range(0, 2))
                                0: send_item(REQ_CHAR, pick_symbol());
                                1: ;
                                default:
                                begin
                                    send_item(REQ_CHAR, pick_symbol());
                                    send_item(REQ_CHAR, pat_store[j]);
                                end
                            endcase
                        end
                        else
                            send_item(REQ_CHAR, pat_store[j]);
                    end
                    // spare edits become trailing characters
                    while (edits_left > 0 && $urandom_range(0, 1) == 1)
                    begin
                        send_item(REQ_CHAR, pick_symbol());
                        edits_left--;
                    end
                end
                else if (kind < 9)
                begin
                    // noise over the whole byte range
                    repeat ($urandom_range(1, 6)) send_item(REQ_CHAR, SYM_W'($urandom_range(0, 255)));
                end
                else
                    send_item(REQ_START, SYM_W'($urandom));
            end
        end

        // drain, then allow for the row latency
        wait_idle();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("levenshtein_automaton_step_top_test OK");
        else
            $display("levenshtein_automaton_step_top_test NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lev_pkg.sv
rtl/core/lev_regs.sv
rtl/core/lev_cell.sv
rtl/core/levenshtein_automaton_step_top.sv
tb/sv/levenshtein_automaton_step_checker.sv
tb/sv/levenshtein_automaton_step_top_test.sv
